// ===== rtl/vdi_pkg.sv =====
// shared types and constants for the vertex deduplication indexer
package vdi_pkg;

   localparam int FIELD_W    = 32;
   localparam int NUM_FIELDS = 12;
   localparam int KEY_W      = FIELD_W * NUM_FIELDS;
   localparam int INDEX_W    = 8;
   localparam int SAVED_W    = 16;

   typedef logic [KEY_W-1:0]   key_type;
   typedef logic [SAVED_W-1:0] saved_type;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_SCAN
   } state_type;

endpackage

// ===== rtl/vdi_key_store.sv =====
// unique vertex key memory, one write port and one registered read port
module vdi_key_store
   import vdi_pkg::*;
#(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output key_type       rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  key_type       wr_data
);

   key_type mem [DEPTH];
   key_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/vertex_dedup_indexer.sv =====
// vertex deduplication indexer: scans the unique vertex store and appends new keys
//
// A vertex (twelve 32-bit fields, compared as raw bits) is taken when start is
// high and busy is low. The block then reads the stored unique vertices one per
// cycle from a single memory read port, comparing each against the vertex.
// The first equal entry ends the scan; its index is returned with
// rsp_was_duplicate set and the saturating duplicate total advanced. With no
// match the vertex is written to the next free entry and that index returned;
// when the store already holds MAX_VERTICES entries rsp_table_full is set,
// nothing is stored and the index reads zero.
// rsp_valid is registered from the scan decision. The scan issues one memory
// read per stored entry and compares each entry when its registered read data
// returns; the decision follows the last compare, or an early match.
// The result is shown for exactly one cycle with rsp_valid; the receiver cannot
// stall it. busy is high from acceptance until the result shows, so the next
// transaction can be accepted in the cycle the result shows.
// Synchronous reset empties the store logically (count to zero) and clears the
// duplicate total; the memory itself needs no clearing pass.
module vertex_dedup_indexer
   import vdi_pkg::*;
#(
   parameter int MAX_VERTICES = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [FIELD_W-1:0] req_pos_x,
   input  logic [FIELD_W-1:0] req_pos_y,
   input  logic [FIELD_W-1:0] req_pos_z,
   input  logic [FIELD_W-1:0] req_col_r,
   input  logic [FIELD_W-1:0] req_col_g,
   input  logic [FIELD_W-1:0] req_col_b,
   input  logic [FIELD_W-1:0] req_col_a,
   input  logic [FIELD_W-1:0] req_norm_x,
   input  logic [FIELD_W-1:0] req_norm_y,
   input  logic [FIELD_W-1:0] req_norm_z,
   input  logic [FIELD_W-1:0] req_tex_u,
   input  logic [FIELD_W-1:0] req_tex_v,
   output logic               rsp_valid,
   output logic [INDEX_W-1:0] rsp_vertex_index,
   output logic               rsp_was_duplicate,
   output logic               rsp_table_full,
   output logic [SAVED_W-1:0] rsp_saved_total
);

   localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam int IW = (AW > INDEX_W) ? AW : INDEX_W;
   localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_VERTICES);

   state_type state_ff, state_in;

   key_type       key_ff, key_in;
   logic [CW-1:0] issue_ff, issue_in;
   logic          cmp_valid_ff, cmp_valid_in;
   logic [AW-1:0] cmp_addr_ff, cmp_addr_in;
   logic [CW-1:0] count_ff, count_in;
   saved_type     saved_ff, saved_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic               rsp_dup_ff, rsp_dup_in;
   logic               rsp_full_ff, rsp_full_in;

   logic    accept;
   logic    rd_en;
   logic    rd_more;
   logic    match;
   logic    scan_done;
   logic    wr_en;
   key_type rd_data;
   logic [IW-1:0] idx_wide;

   assign accept  = start && (state_ff == ST_IDLE);
   assign rd_more = (issue_ff < count_ff);
   assign match   = cmp_valid_ff && (rd_data == key_ff);
   assign scan_done = (state_ff == ST_SCAN) && (match || (!rd_more && !cmp_valid_ff));
   assign rd_en   = (state_ff == ST_SCAN) && rd_more && !match;
   assign wr_en   = scan_done && !match && (count_ff != COUNT_MAX);

   vdi_key_store #(
      .DEPTH (MAX_VERTICES),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[AW-1:0]),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (key_ff)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and result
   always_comb begin
      key_in       = key_ff;
      issue_in     = issue_ff;
      cmp_valid_in = 1'b0;
      cmp_addr_in  = cmp_addr_ff;
      count_in     = count_ff;
      saved_in     = saved_ff;
      rsp_valid_in = 1'b0;
      rsp_index_in = rsp_index_ff;
      rsp_dup_in   = rsp_dup_ff;
      rsp_full_in  = rsp_full_ff;
      idx_wide     = '0;

      if (accept) begin
         key_in   = {req_tex_v, req_tex_u, req_norm_z, req_norm_y, req_norm_x,
                     req_col_a, req_col_b, req_col_g, req_col_r,
                     req_pos_z, req_pos_y, req_pos_x};
         issue_in = '0;
      end

      if (rd_en) begin
         issue_in     = issue_ff + CW'(1);
         cmp_valid_in = 1'b1;
         cmp_addr_in  = issue_ff[AW-1:0];
      end

      if (scan_done) begin
         rsp_valid_in = 1'b1;
         if (match) begin
            idx_wide    = IW'(cmp_addr_ff);
            rsp_dup_in  = 1'b1;
            rsp_full_in = 1'b0;
            if (saved_ff != '1) begin
               saved_in = saved_ff + SAVED_W'(1);
            end
         end else if (count_ff != COUNT_MAX) begin
            idx_wide    = IW'(count_ff[AW-1:0]);
            rsp_dup_in  = 1'b0;
            rsp_full_in = 1'b0;
            count_in    = count_ff + CW'(1);
         end else begin
            // store full: nothing stored, index reads zero
            idx_wide    = '0;
            rsp_dup_in  = 1'b0;
            rsp_full_in = 1'b1;
         end
         rsp_index_in = idx_wide[INDEX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_valid_ff <= 1'b0;
         count_ff     <= '0;
         saved_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_valid_ff <= cmp_valid_in;
         count_ff     <= count_in;
         saved_ff     <= saved_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      issue_ff     <= issue_in;
      cmp_addr_ff  <= cmp_addr_in;
      rsp_index_ff <= rsp_index_in;
      rsp_dup_ff   <= rsp_dup_in;
      rsp_full_ff  <= rsp_full_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_vertex_index  = rsp_index_ff;
   assign rsp_was_duplicate = rsp_dup_ff;
   assign rsp_table_full    = rsp_full_ff;
   assign rsp_saved_total   = saved_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_MAX)
      else $error("unique count beyond store depth");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while scan still running");

   a_full_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_table_full) |->
         (!rsp_was_duplicate && rsp_vertex_index == '0 && count_ff == COUNT_MAX))
      else $error("full result inconsistent");

   a_dup_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_was_duplicate) |-> rsp_saved_total != '0)
      else $error("duplicate not counted");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not start a scan");
`endif

endmodule

// ===== test/vertex_dedup_indexer_test.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the vertex deduplication indexer
module vertex_dedup_indexer_test;
   import vdi_pkg::*;

   localparam int STORE_DEPTH  = 256;
   localparam int TAIL_CYCLES  = STORE_DEPTH + 40;
   localparam int RANDOM_ITEMS = 1950;

   localparam saved_type SAVED_MAX = '1;

   localparam logic [FIELD_W-1:0] POS_ZERO  = 32'h0000_0000;
   localparam logic [FIELD_W-1:0] NEG_ZERO  = 32'h8000_0000;
   localparam logic [FIELD_W-1:0] POS_INF   = 32'h7F80_0000;
   localparam logic [FIELD_W-1:0] NEG_INF   = 32'hFF80_0000;
   localparam logic [FIELD_W-1:0] QUIET_NAN = 32'h7FC0_0000;
   localparam logic [FIELD_W-1:0] FP_ONE    = 32'h3F80_0000;
   localparam logic [FIELD_W-1:0] ALL_ONES  = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [FIELD_W-1:0] pos_x;
      logic [FIELD_W-1:0] pos_y;
      logic [FIELD_W-1:0] pos_z;
      logic [FIELD_W-1:0] col_r;
      logic [FIELD_W-1:0] col_g;
      logic [FIELD_W-1:0] col_b;
      logic [FIELD_W-1:0] col_a;
      logic [FIELD_W-1:0] norm_x;
      logic [FIELD_W-1:0] norm_y;
      logic [FIELD_W-1:0] norm_z;
      logic [FIELD_W-1:0] tex_u;
      logic [FIELD_W-1:0] tex_v;
   } vertex_rec;

   typedef struct {
      logic [INDEX_W-1:0] index;
      logic               dup;
      logic               full;
      saved_type          total;
   } lookup_rec;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   vertex_rec          drive_vtx = '0;
   logic               busy;
   logic               rsp_valid;
   logic [INDEX_W-1:0] rsp_vertex_index;
   logic               rsp_was_duplicate;
   logic               rsp_table_full;
   saved_type          rsp_saved_total;

   vertex_rec vertex_queue[$];
   vertex_rec sent_vertices[$];
   vertex_rec known_vertices[$];
   lookup_rec predicted_lookups[$];
   saved_type saved_count = '0;

   int idle_pct       = 0;
   int error_count    = 0;
   int accepted_count = 0;
   int dup_seen       = 0;
   int full_seen      = 0;
   int stored_seen    = 0;

   vertex_dedup_indexer #(
      .MAX_VERTICES(STORE_DEPTH)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_pos_x         (drive_vtx.pos_x),
      .req_pos_y         (drive_vtx.pos_y),
      .req_pos_z         (drive_vtx.pos_z),
      .req_col_r         (drive_vtx.col_r),
      .req_col_g         (drive_vtx.col_g),
      .req_col_b         (drive_vtx.col_b),
      .req_col_a         (drive_vtx.col_a),
      .req_norm_x        (drive_vtx.norm_x),
      .req_norm_y        (drive_vtx.norm_y),
      .req_norm_z        (drive_vtx.norm_z),
      .req_tex_u         (drive_vtx.tex_u),
      .req_tex_v         (drive_vtx.tex_v),
      .rsp_valid         (rsp_valid),
      .rsp_vertex_index  (rsp_vertex_index),
      .rsp_was_duplicate (rsp_was_duplicate),
      .rsp_table_full    (rsp_table_full),
      .rsp_saved_total   (rsp_saved_total)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // first bit-equal stored vertex wins, else append, else report the store full
   function automatic lookup_rec resolve_vertex(vertex_rec v);
      lookup_rec r;
      int hit;
      hit     = -1;
      r.index = '0;
      r.dup   = 1'b0;
      r.full  = 1'b0;
      for (int e = 0; e < known_vertices.size(); e++) begin
         if (known_vertices[e] == v) begin
            hit = e;
            break;
         end
      end
      if (hit >= 0) begin
         r.index = INDEX_W'(hit);
         r.dup   = 1'b1;
         if (saved_count != SAVED_MAX) saved_count++;
      end else if (known_vertices.size() < STORE_DEPTH) begin
         r.index = INDEX_W'(known_vertices.size());
         known_vertices = {known_vertices, v};
      end else begin
         r.full = 1'b1;
      end
      r.total = saved_count;
      return r;
   endfunction

   function automatic logic [FIELD_W-1:0] pick_field();
      logic [FIELD_W-1:0] f;
      f = $urandom();
      if ($urandom_range(3) == 0) begin
         case ($urandom_range(6))
            0: f = POS_ZERO;
            1: f = NEG_ZERO;
            2: f = POS_INF;
            3: f = NEG_INF;
            4: f = QUIET_NAN;
            5: f = ALL_ONES;
            default: f = FP_ONE;
         endcase
      end
      return f;
   endfunction

   function automatic vertex_rec uniform_vertex(logic [FIELD_W-1:0] f);
      return vertex_rec'({NUM_FIELDS{f}});
   endfunction

   // mostly repeats and one-bit near misses of earlier vertices, the rest fresh
   function automatic vertex_rec random_vertex();
      vertex_rec v;
      key_type k;
      int roll;
      roll = $urandom_range(99);
      if (sent_vertices.size() == 0 || roll >= 70) begin
         for (int i = 0; i < NUM_FIELDS; i++) k[FIELD_W*i +: FIELD_W] = pick_field();
         v = vertex_rec'(k);
      end else begin
         v = sent_vertices[$urandom_range(sent_vertices.size() - 1)];
         if (roll >= 40)
            v = vertex_rec'(key_type'(v) ^ (key_type'(1) << $urandom_range(KEY_W - 1)));
      end
      return v;
   endfunction

   task automatic queue_vertex(vertex_rec v);
      sent_vertices = {sent_vertices, v};
      vertex_queue  = {vertex_queue, v};
   endtask

   task automatic drain();
      while (vertex_queue.size() != 0 || start || predicted_lookups.size() != 0)
         @(posedge clock);
   endtask

   task automatic run_phase(int pct);
      idle_pct = pct;
      repeat (RANDOM_ITEMS / 4) queue_vertex(random_vertex());
      drain();
   endtask

   // driver: start stays high until the transaction is taken
   always @(posedge clock) begin
      vertex_rec next_vtx;
      lookup_rec pred;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            pred = resolve_vertex(drive_vtx);
            predicted_lookups = {predicted_lookups, pred};
            accepted_count++;
         end
         if (!start || !busy) begin
            if (vertex_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
               next_vtx = vertex_queue.pop_front();
               drive_vtx <= next_vtx;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      lookup_rec want;
      if (!reset && rsp_valid) begin
         if (predicted_lookups.size() == 0) begin
            $error("result with no transaction outstanding: vertex_index %0d",
                   rsp_vertex_index);
            error_count++;
         end else begin
            want = predicted_lookups.pop_front();
            if (rsp_vertex_index !== want.index) begin
               $error("vertex_index: expected %0d, got %0d", want.index, rsp_vertex_index);
               error_count++;
            end
            if (rsp_was_duplicate !== want.dup) begin
               $error("was_duplicate: expected %0b, got %0b", want.dup, rsp_was_duplicate);
               error_count++;
            end
            if (rsp_table_full !== want.full) begin
               $error("table_full: expected %0b, got %0b", want.full, rsp_table_full);
               error_count++;
            end
            if (rsp_saved_total !== want.total) begin
               $error("saved_total: expected %0d, got %0d", want.total, rsp_saved_total);
               error_count++;
            end
            if (want.dup) dup_seen++;
            else if (want.full) full_seen++;
            else stored_seen++;
         end
      end
   end

   initial begin
      vertex_rec v;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      queue_vertex(uniform_vertex(POS_ZERO));
      queue_vertex(uniform_vertex(ALL_ONES));
      queue_vertex(uniform_vertex(POS_ZERO));
      // identical nan patterns must match
      queue_vertex(uniform_vertex(ALL_ONES));
      // negative zero is a different key from positive zero
      v = uniform_vertex(POS_ZERO);
      v.pos_x = NEG_ZERO;
      queue_vertex(v);
      v = uniform_vertex(POS_ZERO);
      v.tex_v = NEG_ZERO;
      queue_vertex(v);
      queue_vertex(uniform_vertex(QUIET_NAN));
      queue_vertex(uniform_vertex(QUIET_NAN));
      queue_vertex(uniform_vertex(QUIET_NAN | 32'h1));
      queue_vertex(uniform_vertex(POS_INF));
      queue_vertex(uniform_vertex(NEG_INF));
      v = uniform_vertex(POS_ZERO);
      v.col_a = 32'h0000_0001;
      queue_vertex(v);
      v = uniform_vertex(POS_ZERO);
      v.norm_y = FP_ONE;
      queue_vertex(v);
      v = uniform_vertex(ALL_ONES);
      v.col_r = 32'hFFFF_FFFE;
      queue_vertex(v);
      queue_vertex(uniform_vertex(POS_ZERO));
      v = uniform_vertex(POS_ZERO);
      v.pos_x = NEG_ZERO;
      queue_vertex(v);
      drain();

      run_phase(0);
      run_phase(50);
      run_phase(34);
      run_phase(0);

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("%0d transactions checked: %0d stored, %0d duplicates, %0d refused with store full",
               accepted_count, stored_seen, dup_seen, full_seen);
      $display("store filled to %0d entries, duplicate total ended at %0d",
               known_vertices.size(), saved_count);
      if (error_count == 0) begin
         $display("vertex_dedup_indexer: match");
      end else begin
         $display("vertex_dedup_indexer: mismatch");
      end
      $finish;
   end

   initial begin
      #60_000_000;
      $display("vertex_dedup_indexer: mismatch");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/vdi_pkg.sv
rtl/vdi_key_store.sv
rtl/vertex_dedup_indexer.sv
test/vertex_dedup_indexer_test.sv
